### sv/interlaced_frame_quality_gate_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the interlaced frame quality gate
// Clocked concurrent assertions that report through $error.
// ----------------------------------------------------------------------------
`ifndef INTERLACED_FRAME_QUALITY_GATE_ASSERT_SVH
`define INTERLACED_FRAME_QUALITY_GATE_ASSERT_SVH

// Checked on every edge outside reset.
`define IFQG_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define IFQG_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/ifqg_pkg.sv
// ----------------------------------------------------------------------------
// ifqg_pkg
// Shared types and fixed constants of the interlaced frame quality gate.
// ----------------------------------------------------------------------------
`default_nettype none

package ifqg_pkg;

  localparam int CFG_AW = 5;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH      = 3'd0,
    REG_FRAME_HEIGHT     = 3'd1,
    REG_MEAN_DIFF_RATIO  = 3'd2,
    REG_MIN_MEAN         = 3'd3,
    REG_BRIGHTNESS_LEVEL = 3'd4,
    REG_BRIGHT_PERCENT   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [10:0] frame_width;
    logic [10:0] frame_height;
    logic [16:0] mean_diff_ratio;
    logic [7:0]  min_mean_intensity;
    logic [7:0]  brightness_level;
    logic [6:0]  bright_percentage;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    frame_width:        11'd640,
    frame_height:       11'd480,
    mean_diff_ratio:    17'd6554,
    min_mean_intensity: 8'd30,
    brightness_level:   8'd0,
    bright_percentage:  7'd0
  };

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EVAL = 2'd1,
    ST_EMIT = 2'd2
  } state_t;

  // Evaluation steps; each but STEP_DAY issues one multiply on the shared unit.
  typedef enum logic [2:0] {
    STEP_N      = 3'd0,
    STEP_THRESH = 3'd1,
    STEP_RATIO  = 3'd2,
    STEP_SIZE   = 3'd3,
    STEP_SZPCT  = 3'd4,
    STEP_BRIGHT = 3'd5,
    STEP_DAY    = 3'd6
  } step_t;

  localparam logic [1:0] DN_NIGHT = 2'd0;
  localparam logic [1:0] DN_DAY   = 2'd1;
  localparam logic [1:0] DN_UNDET = 2'd2;

  localparam logic [6:0] PERCENT_SCALE = 7'd100;
  localparam int         RATIO_SHIFT   = 17;

endpackage

`default_nettype wire

### sv/ifqg_regs.sv
// ----------------------------------------------------------------------------
// ifqg_regs
// APB-style register file holding the frame geometry and decision thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

module ifqg_regs (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [ifqg_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [ifqg_pkg::DATA_W-1:0]  pwdata,
  output logic      [ifqg_pkg::DATA_W-1:0]  prdata,
  output logic                              pready,
  output ifqg_pkg::cfg_t                    cfg
);
  import ifqg_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (wr) begin
      unique case (idx)
        REG_FRAME_WIDTH:      cfg.frame_width        <= pwdata[10:0];
        REG_FRAME_HEIGHT:     cfg.frame_height       <= pwdata[10:0];
        REG_MEAN_DIFF_RATIO:  cfg.mean_diff_ratio    <= pwdata[16:0];
        REG_MIN_MEAN:         cfg.min_mean_intensity <= pwdata[7:0];
        REG_BRIGHTNESS_LEVEL: cfg.brightness_level   <= pwdata[7:0];
        REG_BRIGHT_PERCENT:   cfg.bright_percentage  <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FRAME_WIDTH:      prdata = DATA_W'(cfg.frame_width);
      REG_FRAME_HEIGHT:     prdata = DATA_W'(cfg.frame_height);
      REG_MEAN_DIFF_RATIO:  prdata = DATA_W'(cfg.mean_diff_ratio);
      REG_MIN_MEAN:         prdata = DATA_W'(cfg.min_mean_intensity);
      REG_BRIGHTNESS_LEVEL: prdata = DATA_W'(cfg.brightness_level);
      REG_BRIGHT_PERCENT:   prdata = DATA_W'(cfg.bright_percentage);
      default:              prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### sv/ifqg_accum.sv
// ----------------------------------------------------------------------------
// ifqg_accum
// Raster position tracking, half-frame sums and bright sample count.
// ----------------------------------------------------------------------------
`default_nettype none

module ifqg_accum #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst,
  input  wire logic                                         take,
  input  wire logic [7:0]                                   luma,
  input  wire logic [$clog2(MAX_WIDTH+1)-1:0]               eff_w,
  input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]              eff_h,
  input  wire logic [7:0]                                   bright_level,
  input  wire logic                                         clr,
  output logic                                              frame_end,
  output logic      [$clog2(MAX_WIDTH*MAX_HEIGHT)+7:0]      sum_even,
  output logic      [$clog2(MAX_WIDTH*MAX_HEIGHT)+7:0]      sum_odd,
  output logic      [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]      bright
);
  import ifqg_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int BW    = $clog2(MAX_WIDTH*MAX_HEIGHT);
  localparam int SUM_W = BW + 8;

  logic [CW-1:0] col_pos;
  logic [RW-1:0] row_pos;
  logic          col_last;
  logic          row_last;
  logic          counted;

  // A row or frame ends once the next position reaches or passes the size.
  assign col_last  = (32'(col_pos) + 32'd1) >= 32'(eff_w);
  assign row_last  = (32'(row_pos) + 32'd1) >= 32'(eff_h);
  assign counted   = 32'(row_pos) >= 32'd2;
  assign frame_end = take & col_last & row_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos  <= '0;
      row_pos  <= '0;
      sum_even <= '0;
      sum_odd  <= '0;
      bright   <= '0;
    end else begin
      if (clr) begin
        sum_even <= '0;
        sum_odd  <= '0;
        bright   <= '0;
      end else if (take && counted) begin
        if (row_pos[0]) begin
          sum_odd <= sum_odd + SUM_W'(luma);
        end else begin
          sum_even <= sum_even + SUM_W'(luma);
        end
        if (col_pos != '0 && luma > bright_level) begin
          bright <= bright + BW'(1);
        end
      end
      if (take) begin
        if (col_last) begin
          col_pos <= '0;
          if (row_last) begin
            row_pos <= '0;
          end else begin
            row_pos <= row_pos + RW'(1);
          end
        end else begin
          col_pos <= col_pos + CW'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

### sv/ifqg_alu.sv
// ----------------------------------------------------------------------------
// ifqg_alu
// Shared multiplier with registered product, and one magnitude comparator.
// ----------------------------------------------------------------------------
`default_nettype none

module ifqg_alu #(
  parameter int MA_W = 28,
  parameter int MB_W = 20
) (
  input  wire logic                   clk,
  input  wire logic [MA_W-1:0]        op_a,
  input  wire logic [MB_W-1:0]        op_b,
  input  wire logic [MA_W+MB_W-1:0]   cmp_a,
  input  wire logic [MA_W+MB_W-1:0]   cmp_b,
  output logic      [MA_W+MB_W-1:0]   prod,
  output logic                        gt
);

  always_ff @(posedge clk) begin
    prod <= (MA_W+MB_W)'(op_a) * (MA_W+MB_W)'(op_b);
  end

  assign gt = cmp_a > cmp_b;

endmodule

`default_nettype wire

### sv/ifqg_eval.sv
// ----------------------------------------------------------------------------
// ifqg_eval
// Frame-end sequencer: drives the shared unit through the decision steps,
// keeps the drop and frame counters and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ifqg_eval #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst,
  input  wire logic                                          frame_end,
  input  wire ifqg_pkg::cfg_t                                cfg,
  input  wire logic [$clog2(MAX_WIDTH+1)-1:0]                eff_w,
  input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]               eff_h,
  input  wire logic [$clog2(MAX_WIDTH*MAX_HEIGHT)+7:0]       sum_even,
  input  wire logic [$clog2(MAX_WIDTH*MAX_HEIGHT)+7:0]       sum_odd,
  input  wire logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]       bright,
  input  wire logic [$clog2(MAX_WIDTH*MAX_HEIGHT)+8+
                     (($clog2(MAX_WIDTH*MAX_HEIGHT) > 17) ?
                      $clog2(MAX_WIDTH*MAX_HEIGHT) : 17)-1:0] prod,
  input  wire logic                                          gt,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)+7:0]            op_a,
  output logic [(($clog2(MAX_WIDTH*MAX_HEIGHT) > 17) ?
                 $clog2(MAX_WIDTH*MAX_HEIGHT) : 17)-1:0]     op_b,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)+8+
                (($clog2(MAX_WIDTH*MAX_HEIGHT) > 17) ?
                 $clog2(MAX_WIDTH*MAX_HEIGHT) : 17)-1:0]     cmp_a,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)+8+
                (($clog2(MAX_WIDTH*MAX_HEIGHT) > 17) ?
                 $clog2(MAX_WIDTH*MAX_HEIGHT) : 17)-1:0]     cmp_b,
  output logic                                               idle,
  output logic                                               clr,
  input  wire logic                                          result_ready,
  output logic                                               result_valid,
  output logic                                               frame_passed,
  output logic [1:0]                                         day_night,
  output logic [31:0]                                        dropped_frames,
  output logic [31:0]                                        frame_index,
  output logic [26:0]                                        even_field_sum,
  output logic [26:0]                                        odd_field_sum
);
  import ifqg_pkg::*;

  localparam int EW_W  = $clog2(MAX_WIDTH+1);
  localparam int EH_W  = $clog2(MAX_HEIGHT+1);
  localparam int BW    = $clog2(MAX_WIDTH*MAX_HEIGHT);
  localparam int SUM_W = BW + 8;
  localparam int MA_W  = SUM_W;
  localparam int MB_W  = (BW > 17) ? BW : 17;
  localparam int PW    = MA_W + MB_W;

  state_t           state;
  state_t           state_next;
  step_t            step;
  logic [PW-1:0]    hold;
  logic             low_mean;
  logic             ratio_bad;
  logic             is_day;
  logic [31:0]      drop_total;
  logic [31:0]      frame_total;
  logic             load;
  logic             drop;
  logic [SUM_W-1:0] total;
  logic [SUM_W-1:0] diff;
  logic [EH_W-1:0]  half_rows;
  logic [7:0]       minm;

  assign total     = SUM_W'({1'b0, sum_even} + {1'b0, sum_odd});
  assign diff      = (sum_even > sum_odd) ? sum_even - sum_odd : sum_odd - sum_even;
  assign half_rows = (eff_h - EH_W'(2)) >> 1;
  assign minm      = (cfg.min_mean_intensity == 8'd0) ? 8'd1 : cfg.min_mean_intensity;
  assign drop      = low_mean | ratio_bad;

  // Operand and compare selection per step; prod holds the previous step's product.
  always_comb begin
    op_a  = '0;
    op_b  = '0;
    cmp_a = '0;
    cmp_b = '0;
    unique case (step)
      STEP_N: begin
        op_a = MA_W'(eff_w);
        op_b = MB_W'(half_rows);
      end
      STEP_THRESH: begin
        op_a = MA_W'({minm, 1'b0});
        op_b = prod[MB_W-1:0];
      end
      STEP_RATIO: begin
        op_a  = MA_W'(total);
        op_b  = MB_W'(cfg.mean_diff_ratio);
        cmp_a = prod;
        cmp_b = PW'(total);
      end
      STEP_SIZE: begin
        op_a  = MA_W'(eff_w - EW_W'(1));
        op_b  = MB_W'(eff_h - EH_W'(2));
        cmp_a = PW'({diff, {RATIO_SHIFT{1'b0}}});
        cmp_b = prod;
      end
      STEP_SZPCT: begin
        op_a = MA_W'(cfg.bright_percentage);
        op_b = prod[MB_W-1:0];
      end
      STEP_BRIGHT: begin
        op_a = MA_W'(PERCENT_SCALE);
        op_b = MB_W'(bright);
      end
      STEP_DAY: begin
        cmp_a = prod;
        cmp_b = hold;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (frame_end) state_next = ST_EVAL;
      ST_EVAL: if (step == STEP_DAY) state_next = ST_EMIT;
      ST_EMIT: if (!result_valid || result_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    idle = 1'b0;
    load = 1'b0;
    unique case (state)
      ST_IDLE: idle = 1'b1;
      ST_EVAL: ;
      ST_EMIT: load = !result_valid || result_ready;
      default: ;
    endcase
  end

  assign clr = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= STEP_N;
    end else begin
      state <= state_next;
      step  <= (state == ST_EVAL && step != STEP_DAY) ? step_t'(step + 3'd1) : STEP_N;
    end
  end

  // Latch comparator outcomes, and the size-times-percentage product, at the steps that consume them.
  always_ff @(posedge clk) begin
    if (state == ST_EVAL) begin
      unique case (step)
        STEP_RATIO:  low_mean  <= gt;
        STEP_SIZE:   ratio_bad <= gt;
        STEP_BRIGHT: hold      <= prod;
        STEP_DAY:    is_day    <= gt;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      drop_total   <= '0;
      frame_total  <= '0;
    end else if (load) begin
      result_valid <= 1'b1;
      frame_total  <= frame_total + 32'd1;
      if (drop && drop_total != '1) begin
        drop_total <= drop_total + 32'd1;
      end
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_passed   <= !drop;
      frame_index    <= frame_total;
      even_field_sum <= 27'(sum_even);
      odd_field_sum  <= 27'(sum_odd);
      if (cfg.brightness_level == 8'd0 || cfg.bright_percentage == 7'd0) begin
        day_night <= DN_UNDET;
      end else begin
        day_night <= is_day ? DN_DAY : DN_NIGHT;
      end
    end
  end

  assign dropped_frames = drop_total;

endmodule

`default_nettype wire

### sv/interlaced_frame_quality_gate.sv
// ----------------------------------------------------------------------------
// interlaced_frame_quality_gate
// Per-frame reliability and day/night decision over a raster luma stream.
// ----------------------------------------------------------------------------
// Usage:
//   Luma samples arrive on sample_valid/sample_ready in raster order, one
//   transfer per cycle while a frame is being accumulated. The last sample
//   of a frame starts the decision: the shared multiplier and comparator are
//   stepped through seven operations (samples per field, mean threshold,
//   ratio product, frame size, size times percentage, bright count times
//   one hundred, day compare), then the load step writes the result register.
//   sample_ready is low through these steps and the load step, so no sample
//   is taken while a decision is running; the load step sets result_valid.
//   A stalled result holds in the output register while the next frame is
//   accumulated; the following frame end waits in the load step until the
//   register is free.
//   Reset (rst, synchronous) returns the registers to their defaults and
//   clears positions, sums and the drop and frame counters. Registers are
//   written through the APB port, pready tied high.
// ----------------------------------------------------------------------------
`default_nettype none

module interlaced_frame_quality_gate #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [ifqg_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [ifqg_pkg::DATA_W-1:0]  pwdata,
  output logic      [ifqg_pkg::DATA_W-1:0]  prdata,
  output logic                              pready,
  input  wire logic                         sample_valid,
  output logic                              sample_ready,
  input  wire logic [7:0]                   luma,
  output logic                              result_valid,
  input  wire logic                         result_ready,
  output logic                              frame_passed,
  output logic      [1:0]                   day_night,
  output logic      [31:0]                  dropped_frames,
  output logic      [31:0]                  frame_index,
  output logic      [26:0]                  even_field_sum,
  output logic      [26:0]                  odd_field_sum
);
  import ifqg_pkg::*;

  localparam int EW_W  = $clog2(MAX_WIDTH+1);
  localparam int EH_W  = $clog2(MAX_HEIGHT+1);
  localparam int BW    = $clog2(MAX_WIDTH*MAX_HEIGHT);
  localparam int SUM_W = BW + 8;
  localparam int MA_W  = SUM_W;
  localparam int MB_W  = (BW > 17) ? BW : 17;
  localparam int PW    = MA_W + MB_W;

  cfg_t             cfg;
  logic [EW_W-1:0]  eff_w;
  logic [EH_W-1:0]  eff_h_raw;
  logic [EH_W-1:0]  eff_h;
  logic             take;
  logic             frame_end;
  logic             clr;
  logic             idle;
  logic [SUM_W-1:0] sum_even;
  logic [SUM_W-1:0] sum_odd;
  logic [BW-1:0]    bright;
  logic [MA_W-1:0]  op_a;
  logic [MB_W-1:0]  op_b;
  logic [PW-1:0]    cmp_a;
  logic [PW-1:0]    cmp_b;
  logic [PW-1:0]    prod;
  logic             gt;

  // Clamp geometry into the supported range; height is forced even.
  always_comb begin
    if (cfg.frame_width < 11'd2) begin
      eff_w = EW_W'(2);
    end else if (32'(cfg.frame_width) > MAX_WIDTH) begin
      eff_w = EW_W'(MAX_WIDTH);
    end else begin
      eff_w = EW_W'(cfg.frame_width);
    end
    if (cfg.frame_height < 11'd4) begin
      eff_h_raw = EH_W'(4);
    end else if (32'(cfg.frame_height) > MAX_HEIGHT) begin
      eff_h_raw = EH_W'(MAX_HEIGHT);
    end else begin
      eff_h_raw = EH_W'(cfg.frame_height);
    end
    eff_h = {eff_h_raw[EH_W-1:1], 1'b0};
  end

  assign sample_ready = idle;
  assign take         = sample_valid & idle;

  ifqg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ifqg_accum #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_accum (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .luma         (luma),
    .eff_w        (eff_w),
    .eff_h        (eff_h),
    .bright_level (cfg.brightness_level),
    .clr          (clr),
    .frame_end    (frame_end),
    .sum_even     (sum_even),
    .sum_odd      (sum_odd),
    .bright       (bright)
  );

  ifqg_alu #(
    .MA_W (MA_W),
    .MB_W (MB_W)
  ) u_alu (
    .clk   (clk),
    .op_a  (op_a),
    .op_b  (op_b),
    .cmp_a (cmp_a),
    .cmp_b (cmp_b),
    .prod  (prod),
    .gt    (gt)
  );

  ifqg_eval #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_eval (
    .clk            (clk),
    .rst            (rst),
    .frame_end      (frame_end),
    .cfg            (cfg),
    .eff_w          (eff_w),
    .eff_h          (eff_h),
    .sum_even       (sum_even),
    .sum_odd        (sum_odd),
    .bright         (bright),
    .prod           (prod),
    .gt             (gt),
    .op_a           (op_a),
    .op_b           (op_b),
    .cmp_a          (cmp_a),
    .cmp_b          (cmp_b),
    .idle           (idle),
    .clr            (clr),
    .result_ready   (result_ready),
    .result_valid   (result_valid),
    .frame_passed   (frame_passed),
    .day_night      (day_night),
    .dropped_frames (dropped_frames),
    .frame_index    (frame_index),
    .even_field_sum (even_field_sum),
    .odd_field_sum  (odd_field_sum)
  );

endmodule

`default_nettype wire

### sv/ifqg_checker.sv
// ----------------------------------------------------------------------------
// ifqg_checker
// Port-level checks on the result channel of the quality gate.
// ----------------------------------------------------------------------------
`default_nettype none

`include "interlaced_frame_quality_gate_assert.svh"

module ifqg_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        result_valid,
  input wire logic        result_ready,
  input wire logic        frame_passed,
  input wire logic [31:0] dropped_frames,
  input wire logic [31:0] frame_index
);

  // Reset empties the result register.
  `IFQG_ASSERT_ANY(a_reset_empty, rst |=> !result_valid, "result_valid high after reset")

  // A stalled result holds its counters.
  `IFQG_ASSERT_CLK(a_stall_hold, result_valid && !result_ready |=> result_valid && $stable(frame_index) && $stable(dropped_frames), "stalled result changed")

  // A dropped frame has been counted.
  `IFQG_ASSERT_CLK(a_drop_counted, result_valid && !frame_passed |-> dropped_frames != 32'd0, "dropped frame not counted")

  // No result is shown twice: after a transfer, any result is a new frame.
  `IFQG_ASSERT_CLK(a_no_repeat, result_valid && result_ready |=> !result_valid || !$stable(frame_index), "result repeated")

endmodule

bind interlaced_frame_quality_gate ifqg_checker u_ifqg_checker (
  .clk            (clk),
  .rst            (rst),
  .result_valid   (result_valid),
  .result_ready   (result_ready),
  .frame_passed   (frame_passed),
  .dropped_frames (dropped_frames),
  .frame_index    (frame_index)
);

`default_nettype wire
